[design/dsu_pkg.sv]
// Shared types, constants and helpers of the double sphere unprojection block.
// Holds config register codes, reset values, stage payload structs and
// the fixed point rounding helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_XI       = 3'd5;

    localparam logic [15:0]        RST_FOCAL_X  = 16'd8000;
    localparam logic [15:0]        RST_FOCAL_Y  = 16'd8000;
    localparam logic [15:0]        RST_CENTER_X = 16'd5120;
    localparam logic [15:0]        RST_CENTER_Y = 16'd3840;
    localparam logic [16:0]        RST_ALPHA    = 17'd32768;
    localparam logic signed [18:0] RST_XI       = 19'sd0;

    localparam logic signed [18:0] RAY_MAX = 19'sh3FFFF;
    localparam logic signed [18:0] RAY_MIN = 19'sh40000;

    // payload that rides along the first square root
    typedef struct packed {
        logic signed [36:0] num;
        logic [32:0]        r2;
        logic signed [24:0] mx;
        logic signed [24:0] my;
        logic               inv;
    } t_sq1_side;

    // payload that rides along the mz divider
    typedef struct packed {
        logic               neg;
        logic [32:0]        r2;
        logic signed [24:0] mx;
        logic signed [24:0] my;
        logic               inv;
    } t_dmz_side;

    // payload that rides along the second square root
    typedef struct packed {
        logic signed [34:0] mzx;
        logic [46:0]        kden;
        logic signed [31:0] mz;
        logic signed [24:0] mx;
        logic signed [24:0] my;
        logic               inv;
    } t_sq2_side;

    // payload that rides along the k divider
    typedef struct packed {
        logic               neg;
        logic signed [31:0] mz;
        logic signed [24:0] mx;
        logic signed [24:0] my;
        logic               inv;
    } t_dk_side;

    // divide by 2^16, truncating toward zero
    function automatic logic signed [63:0] f_sdiv16(input logic signed [63:0] v);
        logic signed [63:0] b;
        b = v + (v[63] ? 64'sd65535 : 64'sd0);
        return b >>> 16;
    endfunction

    function automatic logic signed [18:0] f_sat19(input logic signed [63:0] v);
        logic signed [18:0] r;
        if (v > 64'(RAY_MAX)) begin
            r = RAY_MAX;
        end else if (v < 64'(RAY_MIN)) begin
            r = RAY_MIN;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/dsu_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Computes the low Q_W quotient bits and flags overflow when the quotient
// needs more. Carries a side payload in step with the data. No package.
`timescale 1ns / 1ps
`default_nettype none

module dsu_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              r_valid [Q_W+1];
    logic [DEN_W-1:0]  r_rem   [Q_W+1];
    logic [Q_W-1:0]    r_low   [Q_W+1];
    logic [Q_W-1:0]    r_quo   [Q_W+1];
    logic [DEN_W-1:0]  r_den   [Q_W+1];
    logic              r_ovf   [Q_W+1];
    logic [SIDE_W-1:0] r_side  [Q_W+1];

    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] dn;
    logic             ovf0;

    // the quotient overflows exactly when the high dividend part reaches den
    assign hi   = CMP_W'(i_num[NUM_W-1:Q_W]);
    assign dn   = CMP_W'(i_den);
    assign ovf0 = (hi >= dn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= ovf0 ? '0 : hi[DEN_W-1:0];
            r_low[0]  <= i_num[Q_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= ovf0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= Q_W; s++) begin : g_stage
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        logic           ge;

        assign t  = {r_rem[s-1], r_low[s-1][Q_W-1]};
        assign d  = t - {1'b0, r_den[s-1]};
        assign ge = (t >= {1'b0, r_den[s-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= r_valid[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
                r_low[s]  <= r_low[s-1] << 1;
                r_quo[s]  <= {r_quo[s-1][Q_W-2:0], ge};
                r_den[s]  <= r_den[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_valid[Q_W];
    assign o_quo   = r_quo[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

`default_nettype wire

[design/dsu_sqrt.sv]
// Pipelined integer square root, one root bit per stage (floor of root).
// Radicand is 2*R_W bits, root is R_W bits. Carries a side payload in step.
// No package.
`timescale 1ns / 1ps
`default_nettype none

module dsu_sqrt #(
    parameter int R_W    = 25,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2*R_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [R_W-1:0]     o_root,
    output logic [SIDE_W-1:0]  o_side
);

    logic               r_valid [R_W+1];
    logic [2*R_W-1:0]   r_rad   [R_W+1];
    logic [R_W:0]       r_rem   [R_W+1];
    logic [R_W-1:0]     r_root  [R_W+1];
    logic [SIDE_W-1:0]  r_side  [R_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= R_W; s++) begin : g_stage
        logic [R_W+2:0] t;
        logic [R_W+2:0] trial;
        logic [R_W+2:0] d;
        logic           ge;

        // bring down the next two radicand bits and try root*4+1
        assign t     = {r_rem[s-1], r_rad[s-1][2*R_W-1 -: 2]};
        assign trial = {1'b0, r_root[s-1], 2'b01};
        assign d     = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= r_valid[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= r_rad[s-1] << 2;
                r_rem[s]  <= ge ? d[R_W:0] : t[R_W:0];
                r_root[s] <= {r_root[s-1][R_W-2:0], ge};
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_valid[R_W];
    assign o_root  = r_root[R_W];
    assign o_side  = r_side[R_W];

endmodule

`default_nettype wire

[design/double_sphere_unproject.sv]
// Double sphere camera unprojection: pixel coordinate in, camera ray out.
// Uses dsu_pkg, dsu_div (pipelined divider) and dsu_sqrt (pipelined root).
//
// Channels: pixel items enter on i_in_valid/o_in_ready, rays leave on
// o_out_valid/i_out_ready. Intrinsics, alpha and xi are written through the
// cfg port (i_cfg_valid, index, data); o_cfg_ready is always high and an
// unknown index is dropped. Write config only while no item is in flight.
// Throughput: one item per clock unless the receiver stalls. The item path
// runs through three bit-serial divider levels (25, 32 and 32 stages),
// the two root units (26 and 33 stages) and the multiply stages between them.
// Invalid geometry (zero focal length, negative radicand, nonpositive
// divisor) gives o_ray_valid low and zero ray components.
// Reset clears every pipeline valid bit and loads the default intrinsics.
// When a ray waits and the receiver stalls, the whole pipeline holds and
// o_in_ready drops, so no item is lost or repeated, and ready returns when the output drains.
`timescale 1ns / 1ps
`default_nettype none

module double_sphere_unproject (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dsu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dsu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_pixel_u,
    input  logic [15:0]                   i_pixel_v,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [18:0]            o_ray_x,
    output logic signed [18:0]            o_ray_y,
    output logic signed [18:0]            o_ray_z,
    output logic                          o_ray_valid
);

    import dsu_pkg::*;

    logic en;

    // config and derived constants
    logic [15:0]        r_focal_x;
    logic [15:0]        r_focal_y;
    logic [15:0]        r_center_x;
    logic [15:0]        r_center_y;
    logic [16:0]        r_alpha;
    logic signed [18:0] r_xi;

    logic [17:0]        r_c_a2;
    logic signed [18:0] r_c_2am1;
    logic signed [17:0] r_c_1ma;
    logic signed [21:0] r_c_1mxi2;

    logic [33:0]        n_asq;
    logic signed [37:0] n_xsq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= RST_FOCAL_X;
            r_focal_y  <= RST_FOCAL_Y;
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_alpha    <= RST_ALPHA;
            r_xi       <= RST_XI;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data[15:0];
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data[15:0];
                CFG_CENTER_X: r_center_x <= i_cfg_data[15:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[15:0];
                CFG_ALPHA:    r_alpha    <= i_cfg_data[16:0];
                CFG_XI:       r_xi       <= $signed(i_cfg_data[18:0]);
                default: begin
                end
            endcase
        end
    end

    assign n_asq = r_alpha * r_alpha;
    assign n_xsq = r_xi * r_xi;

    always_ff @(posedge i_clk) begin
        r_c_a2    <= n_asq[33:16];
        r_c_2am1  <= $signed({1'b0, r_alpha, 1'b0}) - 19'sd65536;
        r_c_1ma   <= 18'sd65536 - $signed({1'b0, r_alpha});
        r_c_1mxi2 <= 22'sd65536 - $signed({1'b0, n_xsq[36:16]});
    end

    // ---------------------------------------------------------------
    // S0: pixel offsets from the principal point
    logic               r_s0_valid;
    logic [15:0]        r_s0_xmag;
    logic [15:0]        r_s0_ymag;
    logic               r_s0_xneg;
    logic               r_s0_yneg;
    logic               r_s0_inv;
    logic signed [16:0] n_dx;
    logic signed [16:0] n_dy;
    logic signed [16:0] n_dxn;
    logic signed [16:0] n_dyn;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign n_dx  = $signed({1'b0, i_pixel_u}) - $signed({1'b0, r_center_x});
    assign n_dy  = $signed({1'b0, i_pixel_v}) - $signed({1'b0, r_center_y});
    assign n_dxn = -n_dx;
    assign n_dyn = -n_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_xneg <= n_dx[16];
            r_s0_yneg <= n_dy[16];
            r_s0_xmag <= n_dx[16] ? n_dxn[15:0] : n_dx[15:0];
            r_s0_ymag <= n_dy[16] ? n_dyn[15:0] : n_dy[15:0];
            r_s0_inv  <= (r_focal_x == 16'd0) || (r_focal_y == 16'd0);
        end
    end

    // normalize: |d| * 2^16 / f
    logic        divx_valid;
    logic [23:0] divx_q;
    logic        divx_ovf;
    logic        divx_side;
    logic        divy_valid;
    logic [23:0] divy_q;
    logic        divy_ovf;
    logic [1:0]  divy_side;

    dsu_div #(.NUM_W(32), .DEN_W(16), .Q_W(24), .SIDE_W(1)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_num   ({r_s0_xmag, 16'h0000}),
        .i_den   (r_focal_x),
        .i_side  (r_s0_xneg),
        .o_valid (divx_valid),
        .o_quo   (divx_q),
        .o_ovf   (divx_ovf),
        .o_side  (divx_side)
    );

    dsu_div #(.NUM_W(32), .DEN_W(16), .Q_W(24), .SIDE_W(2)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_num   ({r_s0_ymag, 16'h0000}),
        .i_den   (r_focal_y),
        .i_side  ({r_s0_yneg, r_s0_inv}),
        .o_valid (divy_valid),
        .o_quo   (divy_q),
        .o_ovf   (divy_ovf),
        .o_side  (divy_side)
    );

    // ---------------------------------------------------------------
    // S1: signed, saturated mx and my
    logic               r_s1_valid;
    logic signed [24:0] r_s1_mx;
    logic signed [24:0] r_s1_my;
    logic               r_s1_inv;
    logic [23:0]        n_mxmag;
    logic [23:0]        n_mymag;

    assign n_mxmag = divx_ovf ? 24'hFFFFFF : divx_q;
    assign n_mymag = divy_ovf ? 24'hFFFFFF : divy_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= divx_valid && divy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mx  <= divx_side ? -$signed({1'b0, n_mxmag}) : $signed({1'b0, n_mxmag});
            r_s1_my  <= divy_side[1] ? -$signed({1'b0, n_mymag}) : $signed({1'b0, n_mymag});
            r_s1_inv <= divy_side[0];
        end
    end

    // S2: squares
    logic               r_s2_valid;
    logic [47:0]        r_s2_sqx;
    logic [47:0]        r_s2_sqy;
    logic signed [24:0] r_s2_mx;
    logic signed [24:0] r_s2_my;
    logic               r_s2_inv;
    logic signed [49:0] n_sqx;
    logic signed [49:0] n_sqy;

    assign n_sqx = r_s1_mx * r_s1_mx;
    assign n_sqy = r_s1_my * r_s1_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sqx <= n_sqx[47:0];
            r_s2_sqy <= n_sqy[47:0];
            r_s2_mx  <= r_s1_mx;
            r_s2_my  <= r_s1_my;
            r_s2_inv <= r_s1_inv;
        end
    end

    // S3: r2
    logic               r_s3_valid;
    logic [32:0]        r_s3_r2;
    logic signed [24:0] r_s3_mx;
    logic signed [24:0] r_s3_my;
    logic               r_s3_inv;
    logic [48:0]        n_sqsum;

    assign n_sqsum = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_r2  <= n_sqsum[48:16];
            r_s3_mx  <= r_s2_mx;
            r_s3_my  <= r_s2_my;
            r_s3_inv <= r_s2_inv;
        end
    end

    // S4: a2*r2 and (2a-1)*r2
    logic               r_s4_valid;
    logic [50:0]        r_s4_pnum;
    logic signed [52:0] r_s4_prad;
    logic [32:0]        r_s4_r2;
    logic signed [24:0] r_s4_mx;
    logic signed [24:0] r_s4_my;
    logic               r_s4_inv;
    logic [50:0]        n_pnum;
    logic signed [52:0] n_prad;

    assign n_pnum = r_c_a2 * r_s3_r2;
    assign n_prad = r_c_2am1 * $signed({1'b0, r_s3_r2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_pnum <= n_pnum;
            r_s4_prad <= n_prad;
            r_s4_r2   <= r_s3_r2;
            r_s4_mx   <= r_s3_mx;
            r_s4_my   <= r_s3_my;
            r_s4_inv  <= r_s3_inv;
        end
    end

    // S5: num and rad1
    logic               r_s5_valid;
    logic signed [36:0] r_s5_num;
    logic signed [36:0] r_s5_rad1;
    logic [32:0]        r_s5_r2;
    logic signed [24:0] r_s5_mx;
    logic signed [24:0] r_s5_my;
    logic               r_s5_inv;
    logic signed [63:0] n_pradq;
    logic signed [36:0] n_rad1;

    assign n_pradq = f_sdiv16(64'(r_s4_prad));
    assign n_rad1  = 37'sd65536 - $signed(n_pradq[36:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_num  <= 37'sd65536 - $signed({2'b00, r_s4_pnum[50:16]});
            r_s5_rad1 <= n_rad1;
            r_s5_r2   <= r_s4_r2;
            r_s5_mx   <= r_s4_mx;
            r_s5_my   <= r_s4_my;
            r_s5_inv  <= r_s4_inv || n_rad1[36];
        end
    end

    // s1 = sqrt(rad1 * 2^16)
    t_sq1_side   sq1_in;
    t_sq1_side   sq1_out;
    logic        sq1_valid;
    logic [24:0] sq1_root;

    assign sq1_in = '{num: r_s5_num, r2: r_s5_r2, mx: r_s5_mx, my: r_s5_my, inv: r_s5_inv};

    dsu_sqrt #(.R_W(25), .SIDE_W($bits(t_sq1_side))) u_sqrt_1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s5_valid),
        .i_rad   ({r_s5_rad1[33:0], 16'h0000}),
        .i_side  (sq1_in),
        .o_valid (sq1_valid),
        .o_root  (sq1_root),
        .o_side  (sq1_out)
    );

    // S6: alpha*s1
    logic        r_s6_valid;
    logic [41:0] r_s6_ps;
    t_sq1_side   r_s6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (en) begin
            r_s6_valid <= sq1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_ps   <= r_alpha * sq1_root;
            r_s6_side <= sq1_out;
        end
    end

    // S7: den1 and |num|
    logic               r_s7_valid;
    logic [35:0]        r_s7_nmag;
    logic [26:0]        r_s7_den1;
    t_dmz_side          r_s7_side;
    logic signed [27:0] n_den1;
    logic signed [36:0] n_numn;

    assign n_den1 = $signed({2'b00, r_s6_ps[41:16]}) + 28'(r_c_1ma);
    assign n_numn = -r_s6_side.num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (en) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_nmag      <= r_s6_side.num[36] ? n_numn[35:0] : r_s6_side.num[35:0];
            r_s7_den1      <= n_den1[26:0];
            r_s7_side.neg  <= r_s6_side.num[36];
            r_s7_side.r2   <= r_s6_side.r2;
            r_s7_side.mx   <= r_s6_side.mx;
            r_s7_side.my   <= r_s6_side.my;
            r_s7_side.inv  <= r_s6_side.inv || n_den1[27] || (n_den1 == 28'sd0);
        end
    end

    // mz = num * 2^16 / den1
    logic        dmz_valid;
    logic [30:0] dmz_q;
    logic        dmz_ovf;
    t_dmz_side   dmz_out;

    dsu_div #(.NUM_W(52), .DEN_W(27), .Q_W(31), .SIDE_W($bits(t_dmz_side))) u_div_mz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_valid),
        .i_num   ({r_s7_nmag, 16'h0000}),
        .i_den   (r_s7_den1),
        .i_side  (r_s7_side),
        .o_valid (dmz_valid),
        .o_quo   (dmz_q),
        .o_ovf   (dmz_ovf),
        .o_side  (dmz_out)
    );

    // S8: signed, saturated mz
    logic               r_s8_valid;
    logic signed [31:0] r_s8_mz;
    t_dmz_side          r_s8_side;
    logic [30:0]        n_mzmag;

    assign n_mzmag = dmz_ovf ? 31'h7FFFFFFF : dmz_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (en) begin
            r_s8_valid <= dmz_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_mz   <= dmz_out.neg ? -$signed({1'b0, n_mzmag}) : $signed({1'b0, n_mzmag});
            r_s8_side <= dmz_out;
        end
    end

    // S9: mz^2, (1-xi2)*r2, mz*xi
    logic               r_s9_valid;
    logic signed [63:0] r_s9_mzsq;
    logic signed [55:0] r_s9_pxr;
    logic signed [50:0] r_s9_pmx;
    logic signed [31:0] r_s9_mz;
    t_dmz_side          r_s9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (en) begin
            r_s9_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s9_mzsq <= r_s8_mz * r_s8_mz;
            r_s9_pxr  <= r_c_1mxi2 * $signed({1'b0, r_s8_side.r2});
            r_s9_pmx  <= r_s8_mz * r_xi;
            r_s9_mz   <= r_s8_mz;
            r_s9_side <= r_s8_side;
        end
    end

    // S10: rad2, kden, mz*xi scaled
    logic               r_s10_valid;
    logic signed [47:0] r_s10_rad2;
    t_sq2_side          r_s10_side;
    logic [45:0]        n_mz2;
    logic signed [63:0] n_pxrq;
    logic signed [63:0] n_pmxq;
    logic signed [47:0] n_rad2;
    logic [46:0]        n_kden;

    assign n_mz2  = r_s9_mzsq[61:16];
    assign n_pxrq = f_sdiv16(64'(r_s9_pxr));
    assign n_pmxq = f_sdiv16(64'(r_s9_pmx));
    assign n_rad2 = $signed({2'b00, n_mz2}) + $signed(n_pxrq[47:0]);
    assign n_kden = {1'b0, n_mz2} + {14'd0, r_s9_side.r2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_valid <= 1'b0;
        end else if (en) begin
            r_s10_valid <= r_s9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s10_rad2      <= n_rad2;
            r_s10_side.mzx  <= $signed(n_pmxq[34:0]);
            r_s10_side.kden <= n_kden;
            r_s10_side.mz   <= r_s9_mz;
            r_s10_side.mx   <= r_s9_side.mx;
            r_s10_side.my   <= r_s9_side.my;
            r_s10_side.inv  <= r_s9_side.inv || n_rad2[47] || (n_kden == 47'd0);
        end
    end

    // s2 = sqrt(rad2 * 2^16)
    logic        sq2_valid;
    logic [31:0] sq2_root;
    t_sq2_side   sq2_out;

    dsu_sqrt #(.R_W(32), .SIDE_W($bits(t_sq2_side))) u_sqrt_2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s10_valid),
        .i_rad   ({1'b0, r_s10_rad2[46:0], 16'h0000}),
        .i_side  (r_s10_side),
        .o_valid (sq2_valid),
        .o_root  (sq2_root),
        .o_side  (sq2_out)
    );

    // S11: |knum|
    logic               r_s11_valid;
    logic [33:0]        r_s11_kmag;
    logic [46:0]        r_s11_kden;
    t_dk_side           r_s11_side;
    logic signed [34:0] n_knum;
    logic signed [34:0] n_knumn;

    assign n_knum  = sq2_out.mzx + $signed({3'b000, sq2_root});
    assign n_knumn = -n_knum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s11_valid <= 1'b0;
        end else if (en) begin
            r_s11_valid <= sq2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s11_kmag     <= n_knum[34] ? n_knumn[33:0] : n_knum[33:0];
            r_s11_kden     <= sq2_out.kden;
            r_s11_side.neg <= n_knum[34];
            r_s11_side.mz  <= sq2_out.mz;
            r_s11_side.mx  <= sq2_out.mx;
            r_s11_side.my  <= sq2_out.my;
            r_s11_side.inv <= sq2_out.inv;
        end
    end

    // k = knum * 2^16 / kden
    logic        dk_valid;
    logic [30:0] dk_q;
    logic        dk_ovf;
    t_dk_side    dk_out;

    dsu_div #(.NUM_W(50), .DEN_W(47), .Q_W(31), .SIDE_W($bits(t_dk_side))) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s11_valid),
        .i_num   ({r_s11_kmag, 16'h0000}),
        .i_den   (r_s11_kden),
        .i_side  (r_s11_side),
        .o_valid (dk_valid),
        .o_quo   (dk_q),
        .o_ovf   (dk_ovf),
        .o_side  (dk_out)
    );

    // S12: signed, saturated k
    logic               r_s12_valid;
    logic signed [31:0] r_s12_k;
    t_dk_side           r_s12_side;
    logic [30:0]        n_kabs;

    assign n_kabs = dk_ovf ? 31'h7FFFFFFF : dk_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_valid <= 1'b0;
        end else if (en) begin
            r_s12_valid <= dk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s12_k    <= dk_out.neg ? -$signed({1'b0, n_kabs}) : $signed({1'b0, n_kabs});
            r_s12_side <= dk_out;
        end
    end

    // S13: ray products
    logic               r_s13_valid;
    logic signed [56:0] r_s13_kmx;
    logic signed [56:0] r_s13_kmy;
    logic signed [63:0] r_s13_kmz;
    logic               r_s13_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s13_valid <= 1'b0;
        end else if (en) begin
            r_s13_valid <= r_s12_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s13_kmx <= r_s12_k * r_s12_side.mx;
            r_s13_kmy <= r_s12_k * r_s12_side.my;
            r_s13_kmz <= r_s12_k * r_s12_side.mz;
            r_s13_inv <= r_s12_side.inv;
        end
    end

    // output register: scale, subtract xi, saturate, zero when invalid
    logic               r_out_valid;
    logic signed [18:0] r_ray_x;
    logic signed [18:0] r_ray_y;
    logic signed [18:0] r_ray_z;
    logic               r_ray_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s13_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s13_inv) begin
                r_ray_x     <= 19'sd0;
                r_ray_y     <= 19'sd0;
                r_ray_z     <= 19'sd0;
                r_ray_valid <= 1'b0;
            end else begin
                r_ray_x     <= f_sat19(f_sdiv16(64'(r_s13_kmx)));
                r_ray_y     <= f_sat19(f_sdiv16(64'(r_s13_kmy)));
                r_ray_z     <= f_sat19(f_sdiv16(r_s13_kmz) - 64'(r_xi));
                r_ray_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ray_x     = r_ray_x;
    assign o_ray_y     = r_ray_y;
    assign o_ray_z     = r_ray_z;
    assign o_ray_valid = r_ray_valid;

endmodule

`default_nettype wire

[sim/tb_double_sphere_unproject.sv]
// Testbench for the double sphere unprojection block: pixel items in, rays out.
// Predicts each ray with a fixed point model of its own and checks every field.
// Depends on dsu_pkg and double_sphere_unproject.
`timescale 1ns / 1ps

module tb_double_sphere_unproject;
    import dsu_pkg::*;

    localparam int LATENCY = 163;

    typedef struct {
        logic signed [18:0] rx;
        logic signed [18:0] ry;
        logic signed [18:0] rz;
        logic               ok;
    } t_ray;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [15:0]           i_pixel_u;
    logic [15:0]           i_pixel_v;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [18:0]    o_ray_x;
    logic signed [18:0]    o_ray_y;
    logic signed [18:0]    o_ray_z;
    logic                  o_ray_valid;

    double_sphere_unproject uut (.*);

    // own copy of the intrinsics
    longint fx, fy, cx, cy, al, xv;
    t_ray   ray_queue[$];
    int     errors;
    bit     sink_idle_on;
    bit     src_idle_on;
    bit     hold_sink;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint clamp_lim(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [18:0] sat_ray(longint v);
        if (v > 262143) v = 262143;
        if (v < -262144) v = -262144;
        return v[18:0];
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_ray predict_ray(longint u, longint v);
        t_ray   p;
        longint mx, my, r2, num, rad1, s1, den1, mz, mz2, xi2, rad2, s2, kden, k;
        p = '{0, 0, 0, 0};
        if (fx == 0 || fy == 0) return p;
        mx = clamp_lim(((u - cx) * 65536) / fx, 16777215);
        my = clamp_lim(((v - cy) * 65536) / fy, 16777215);
        r2 = (mx * mx + my * my) / 65536;
        num = 65536 - ((al * al) / 65536) * r2 / 65536;
        rad1 = 65536 - (2 * al - 65536) * r2 / 65536;
        if (rad1 < 0) return p;
        s1 = root_floor(rad1 << 16);
        den1 = al * s1 / 65536 + 65536 - al;
        if (den1 <= 0) return p;
        mz = clamp_lim(num * 65536 / den1, 2147483647);
        mz2 = mz * mz / 65536;
        xi2 = xv * xv / 65536;
        rad2 = mz2 + (65536 - xi2) * r2 / 65536;
        if (rad2 < 0) return p;
        s2 = root_floor(rad2 << 16);
        kden = mz2 + r2;
        if (kden <= 0) return p;
        k = clamp_lim((mz * xv / 65536 + s2) * 65536 / kden, 2147483647);
        p.rx = sat_ray(k * mx / 65536);
        p.ry = sat_ray(k * my / 65536);
        p.rz = sat_ray(k * mz / 65536 - xv);
        p.ok = 1;
        return p;
    endfunction

    // when on, sometimes drop valid for a random gap before the next item
    task automatic idle_burst(bit on);
        if (on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    // valid stays high after the item; drain drops it
    task automatic send_pixel(logic [15:0] u, logic [15:0] v);
        idle_burst(src_idle_on);
        i_pixel_u  <= u;
        i_pixel_v  <= v;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ray_queue = {ray_queue, predict_ray(u, v)};
        @(negedge i_clk);
    endtask

    // valid stays high after the write; the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FOCAL_X:  fx = d[15:0];
            CFG_FOCAL_Y:  fy = d[15:0];
            CFG_CENTER_X: cx = d[15:0];
            CFG_CENTER_Y: cy = d[15:0];
            CFG_ALPHA:    al = d[16:0];
            CFG_XI:       xv = $signed(d[18:0]);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 0;
        while (ray_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic set_model(logic [15:0] f_x, logic [15:0] f_y, logic [15:0] c_x,
                             logic [15:0] c_y, logic [16:0] a, logic [18:0] x);
        drain();
        write_reg(CFG_FOCAL_X, f_x);
        write_reg(CFG_FOCAL_Y, f_y);
        write_reg(CFG_CENTER_X, c_x);
        write_reg(CFG_CENTER_Y, c_y);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_XI, x);
        i_cfg_valid <= 0;
    endtask

    task automatic test_directed;
        send_pixel(16'd5120, 16'd3840);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'h5555, 16'hAAAA);
        // unknown index must be dropped
        drain();
        write_reg(3'd6, 19'h7FFFF);
        write_reg(3'd7, 19'h00001);
        i_cfg_valid <= 0;
        send_pixel(16'd6000, 16'd4000);
        // zero focal length
        set_model(16'd0, 16'd8000, 16'd5120, 16'd3840, 17'd32768, 19'd0);
        send_pixel(16'd100, 16'd200);
        // far off-axis: tiny focal saturates mx and my
        set_model(16'd1, 16'd1, 16'd0, 16'd0, 17'd65536, 19'h10000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'd0, 16'd0);
        // alpha above one, extreme xi
        set_model(16'd16, 16'd16, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 19'h20000);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFF0, 16'hFFF0);
        set_model(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 17'd0, 19'h70000);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'hFFFF);
        set_model(16'd300, 16'd300, 16'd5120, 16'd3840, 17'd50000, 19'h7FFFF);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd9000, 16'd7000);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0)
                set_model($urandom_range(0, 7) == 0 ? 16'($urandom) :
                                                      16'($urandom_range(200, 12000)),
                          $urandom_range(0, 7) == 0 ? 16'($urandom) :
                                                      16'($urandom_range(200, 12000)),
                          16'($urandom), 16'($urandom),
                          17'($urandom_range(0, 65536)),
                          19'($signed($urandom_range(0, 196608)) - 65536));
            if ($urandom_range(0, 3) == 0)
                send_pixel(16'($urandom), 16'($urandom));
            else
                send_pixel(16'(cx + $signed($urandom_range(0, 8000)) - 4000),
                           16'(cy + $signed($urandom_range(0, 8000)) - 4000));
        end
    endtask

    task automatic test_backpressure;
        drain();
        hold_sink = 1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_sink = 0;
            end
            for (int i = 0; i < 250; i++) send_pixel(16'($urandom), 16'($urandom));
        join
    endtask

    // sink: ready with random idle bursts
    initial begin
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_out_ready <= 0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    // check each accepted ray against the oldest prediction
    always @(posedge i_clk) begin
        t_ray e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ray_queue.size() == 0) begin
                $display("%0t: unexpected ray %0d %0d %0d %0b", $time,
                         o_ray_x, o_ray_y, o_ray_z, o_ray_valid);
                errors++;
            end else begin
                e = ray_queue.pop_front();
                if (o_ray_x !== e.rx || o_ray_y !== e.ry || o_ray_z !== e.rz ||
                    o_ray_valid !== e.ok) begin
                    $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b", $time,
                             e.rx, e.ry, e.rz, e.ok, o_ray_x, o_ray_y, o_ray_z, o_ray_valid);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        sink_idle_on = 1;
        src_idle_on = 1;
        hold_sink = 0;
        fx = 8000; fy = 8000; cx = 5120; cy = 3840; al = 32768; xv = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_pixel_u = '0;
        i_pixel_v = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_random(600);
        test_backpressure();
        // last stretch without idling
        sink_idle_on = 0;
        src_idle_on = 0;
        test_random(200);
        drain();
        if (errors == 0 && ray_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[files.f]
design/dsu_pkg.sv
design/dsu_div.sv
design/dsu_sqrt.sv
design/double_sphere_unproject.sv
sim/tb_double_sphere_unproject.sv
